### hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Sizes, command and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Number of cells in the list.
  localparam int CAPACITY = 16;
  // Width of a count that must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width of a cell index.
  localparam int IDX_W = $clog2(CAPACITY);
  // Fixed field widths.
  localparam int VAL_W = 32;
  localparam int POS_W = 16;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  // Command codes carried by an input transfer.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_LAST  = 3'd3,
    OP_DEL_POS   = 3'd4,
    OP_DUMP      = 3'd5
  } opcode_e;

  // Status codes carried by an output transfer.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // What the row of cells does in a cycle.
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_ROTATE = 2'd3
  } cell_act_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cell_act_e          act;
    logic [IDX_W-1:0]   slot;   // insert or delete slot
    logic [IDX_W-1:0]   tail;   // last occupied slot, for rotation
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

### hdl/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core: bounded ordered list of signed 32-bit values
// Append, insert at a position, delete first, last or at a position, and
// dump, held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the slave stream; tuser carries the command code and
// tdata the value and the 1-based position. Results leave on the master
// stream; tuser carries the status, tdata the entry count and the value, and
// tlast marks the final result of a command.
// Every command other than dump and the reserved codes gives one result,
// registered in the cycle after its transfer, and a new command can be taken
// every cycle as long as the receiver keeps up. The cells all shift in the
// same cycle, as the command is taken.
// A dump of N entries gives N results, the first registered from the dump
// state and then one per cycle while the receiver keeps up; the row rotates
// by one cell per entry and is back in order after the last one. No command
// is taken until the last entry is out. An empty dump gives one result.
// When the receiver stalls, the result register holds and tready drops until
// it frees. Reset empties the list; the cell contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store_core import pls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] value_in, [47:32] position
  input  logic [47:0] s_axis_tdata_i,
  // [2:0] opcode
  input  logic [OP_W-1:0] s_axis_tuser_i,
  // Result channel.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [CNT_W-1:0] entry_count, then value_out (32 bits), zero padding above
  output logic [((CNT_W+VAL_W+7)/8)*8-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [ST_W-1:0] m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int OUT_DW  = ((CNT_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_DW - CNT_W - VAL_W;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CNT_W-1:0]        entry_count;
  logic signed [VAL_W-1:0] value_out;

  // Command decoder, sequencer and result register.
  pls_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i),
    .value_in_i    (s_axis_tdata_i[VAL_W-1:0]),
    .position_i    (s_axis_tdata_i[VAL_W+POS_W-1:VAL_W]),
    .head_i        (cell_val[0]),
    .cmd_o         (cmd),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (m_axis_tuser_o),
    .entry_count_o (entry_count),
    .value_out_o   (value_out),
    .last_o        (m_axis_tlast_o)
  );

  // Row of cells; each one sees its two neighbors and the head.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_lastc
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = cell_val[g+1];
    end

    pls_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (IDX_W'(g)),
      .cmd_i    (cmd),
      .left_i   (left_val),
      .right_i  (right_val),
      .head_i   (cell_val[0]),
      .value_o  (cell_val[g])
    );
  end

  assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, value_out, entry_count};

endmodule

### hdl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list
// Holds one entry and takes its left or right neighbor, the new value or the
// head entry, as the broadcast command and its own index decide.
// ----------------------------------------------------------------------------
module pls_cell import pls_pkg::*; (
  input  logic                    clk_i,
  input  logic [IDX_W-1:0]        my_idx_i,
  input  cell_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  input  logic signed [VAL_W-1:0] head_i,
  output logic signed [VAL_W-1:0] value_o
);

  logic signed [VAL_W-1:0] value_q, value_d;

  // Select the next entry of this cell.
  always_comb begin
    value_d = value_q;
    case (cmd_i.act)
      ACT_INSERT: begin
        if (my_idx_i == cmd_i.slot) begin
          value_d = cmd_i.value;
        end else if (my_idx_i > cmd_i.slot) begin
          value_d = left_i;
        end
      end
      ACT_DELETE: begin
        if (my_idx_i >= cmd_i.slot) begin
          value_d = right_i;
        end
      end
      ACT_ROTATE: begin
        if (my_idx_i == cmd_i.tail) begin
          value_d = head_i;
        end else if (my_idx_i < cmd_i.tail) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // Entry storage; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### hdl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl: command decoder and sequencer of the positional list store
// Checks each command against the count, drives the cells and holds the
// output register; a dump walks the head of the rotating row.
// ----------------------------------------------------------------------------
module pls_ctrl import pls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] head_i,
  output cell_cmd_t               cmd_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ST_W-1:0]         status_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic                    last_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        remain_q, remain_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic [CNT_W-1:0]        ocount_q, ocount_d;
  logic signed [VAL_W-1:0] oval_q, oval_d;
  logic                    last_q, last_d;

  logic                    out_free;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic                    ins_ok;
  logic                    del_ok;
  logic [POS_W-1:0]        pos_m1;
  logic [CNT_W-1:0]        cnt_m1;
  logic [POS_W:0]          cnt_p1_wide;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign is_full     = (count_q == CNT_W'(CAPACITY));
  assign is_empty    = (count_q == '0);
  assign pos_m1      = position_i - POS_W'(1);
  assign cnt_m1      = count_q - CNT_W'(1);
  assign cnt_p1_wide = (POS_W+1)'(count_q) + (POS_W+1)'(1);
  assign ins_ok      = (position_i != '0) && ({1'b0, position_i} <= cnt_p1_wide);
  assign del_ok      = (position_i != '0) && (position_i <= POS_W'(count_q));

  // Decode the command, drive the cells and load the output register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    ocount_d    = ocount_q;
    oval_d      = oval_q;
    last_d      = last_q;
    cmd_o.act   = ACT_HOLD;
    cmd_o.slot  = pos_m1[IDX_W-1:0];
    cmd_o.tail  = cnt_m1[IDX_W-1:0];
    cmd_o.value = value_in_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          oval_d   = '0;
          last_d   = 1'b1;
          case (opcode_e'(opcode_i))
            OP_APPEND: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.act  = ACT_INSERT;
                cmd_o.slot = count_q[IDX_W-1:0];
                count_d    = count_q + CNT_W'(1);
              end
              out_valid_d = 1'b1;
            end
            OP_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else if (!ins_ok) begin
                status_d = ST_BADPOS;
              end else begin
                cmd_o.act = ACT_INSERT;
                count_d   = count_q + CNT_W'(1);
              end
              out_valid_d = 1'b1;
            end
            OP_DEL_FIRST: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cmd_o.act  = ACT_DELETE;
                cmd_o.slot = '0;
                count_d    = cnt_m1;
              end
              out_valid_d = 1'b1;
            end
            OP_DEL_LAST: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = cnt_m1;
              end
              out_valid_d = 1'b1;
            end
            OP_DEL_POS: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (!del_ok) begin
                status_d = ST_BADPOS;
              end else begin
                cmd_o.act = ACT_DELETE;
                count_d   = cnt_m1;
              end
              out_valid_d = 1'b1;
            end
            OP_DUMP: begin
              if (is_empty) begin
                status_d    = ST_EMPTY;
                out_valid_d = 1'b1;
              end else begin
                remain_d = count_q;
                state_d  = S_DUMP;
              end
            end
            default: begin
              // Unknown commands are dropped without a result.
              status_d = status_q;
              oval_d   = oval_q;
              last_d   = last_q;
            end
          endcase
          ocount_d = count_d;
        end
      end
      S_DUMP: begin
        // Emit the head entry and rotate the row by one slot.
        if (out_free) begin
          cmd_o.act   = ACT_ROTATE;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          ocount_d    = count_q;
          oval_d      = head_i;
          last_d      = (remain_q == CNT_W'(1));
          remain_d    = remain_q - CNT_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      ocount_q    <= '0;
      oval_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      ocount_q    <= ocount_d;
      oval_q      <= oval_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = ocount_q;
  assign value_out_o   = oval_q;
  assign last_o        = last_q;

  // The count never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count exceeds capacity");

  // No command is taken while a dump is running.
  a_no_accept_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !in_ready_o)
    else $error("input ready during dump");

  // An error result carries a zero value and closes the run.
  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> ((oval_q == '0) && last_q))
    else $error("error result with nonzero value or open run");

  // A valid non-dump command gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_APPEND || opcode_i == OP_INSERT ||
                opcode_i == OP_DEL_FIRST || opcode_i == OP_DEL_LAST ||
                opcode_i == OP_DEL_POS)) |=> out_valid_q)
    else $error("missing result after command");

  // The count holds while a dump is running.
  a_count_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |=> (count_q == $past(count_q)))
    else $error("count changed during dump");

endmodule

### verif/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker: result checker for the positional list store
// Watches both stream channels, keeps its own copy of the list, works out
// the results each accepted command must give and compares every accepted
// result against the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pls_checker import pls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel, observed only.
  input  logic        cmd_tvalid_i,
  input  logic        cmd_tready_i,
  // [31:0] value_in, [47:32] position
  input  logic [47:0] cmd_tdata_i,
  // [2:0] opcode
  input  logic [OP_W-1:0] cmd_tuser_i,
  // Result channel, observed only.
  input  logic        res_tvalid_i,
  input  logic        res_tready_i,
  // [CNT_W-1:0] entry_count, then value_out (32 bits), zero padding above
  input  logic [((CNT_W+VAL_W+7)/8)*8-1:0] res_tdata_i,
  // [1:0] status
  input  logic [ST_W-1:0] res_tuser_i,
  input  logic        res_tlast_i,
  // Mismatch count, results still owed, and entries held by the shadow list.
  output int          err_count_o,
  output int          pending_o,
  output logic [CNT_W-1:0] list_size_o
);

  // One result transfer as the list store should produce it.
  typedef struct packed {
    status_e            status;
    logic [CNT_W-1:0]   count;
    logic [VAL_W-1:0]   value;
    logic               last;
  } list_result_t;

  list_result_t     owed_results_q[$];
  logic [VAL_W-1:0] shadow_cells [CAPACITY];
  int unsigned      shadow_count;
  int               mismatches;

  // Queue one result for the current shadow count.
  function automatic void owe_result(status_e st, logic [VAL_W-1:0] val, logic lst);
    list_result_t r;
    r.status = st;
    r.count  = shadow_count[CNT_W-1:0];
    r.value  = val;
    r.last   = lst;
    owed_results_q.push_back(r);
  endfunction

  // Open a gap at slot idx and place v there.
  function automatic void shadow_insert(int unsigned idx, logic [VAL_W-1:0] v);
    for (int unsigned i = shadow_count; i > idx; i--) begin
      shadow_cells[i] = shadow_cells[i-1];
    end
    shadow_cells[idx] = v;
    shadow_count++;
  endfunction

  // Close the gap left by removing slot idx.
  function automatic void shadow_remove(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_count; i++) begin
      shadow_cells[i] = shadow_cells[i+1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow list and queue the results it owes.
  function automatic void apply_list_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] v,
                                             logic [POS_W-1:0] pos);
    int unsigned p;
    p = 32'(pos);
    case (op)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_insert(shadow_count, v);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_INSERT: begin
        // A full list wins over a bad position.
        if (shadow_count >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else if (p < 1 || p > shadow_count + 1) begin
          owe_result(ST_BADPOS, '0, 1'b1);
        end else begin
          shadow_insert(p - 1, v);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_FIRST: begin
        if (shadow_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_remove(0);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_LAST: begin
        if (shadow_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_count--;
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_POS: begin
        // An empty list wins over a bad position.
        if (shadow_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else if (p < 1 || p > shadow_count) begin
          owe_result(ST_BADPOS, '0, 1'b1);
        end else begin
          shadow_remove(p - 1);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            owe_result(ST_OK, shadow_cells[i], i + 1 == shadow_count);
          end
        end
      end
      default: begin
        // Reserved codes are dropped without a result.
      end
    endcase
  endfunction

  // Compare results first, then predict from the command taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    list_result_t got_r;
    if (!rst_ni) begin
      shadow_count = 0;
      mismatches   = 0;
      owed_results_q.delete();
    end else begin
      if (res_tvalid_i && res_tready_i) begin
        got_r.status = status_e'(res_tuser_i);
        got_r.count  = res_tdata_i[CNT_W-1:0];
        got_r.value  = res_tdata_i[CNT_W +: VAL_W];
        got_r.last   = res_tlast_i;
        if (owed_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing owed: st=%0d cnt=%0d val=%h last=%b",
                     $realtime, got_r.status, got_r.count, got_r.value, got_r.last);
          end
        end else begin
          exp_r = owed_results_q.pop_front();
          if (got_r.status !== exp_r.status || got_r.count !== exp_r.count ||
              got_r.value !== exp_r.value || got_r.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected st=%0d cnt=%0d val=%h last=%b",
                       $realtime, exp_r.status, exp_r.count, exp_r.value, exp_r.last);
              $display("%0t:                  actual   st=%0d cnt=%0d val=%h last=%b",
                       $realtime, got_r.status, got_r.count, got_r.value, got_r.last);
            end
          end
        end
      end
      if (cmd_tvalid_i && cmd_tready_i) begin
        apply_list_command(cmd_tuser_i, cmd_tdata_i[VAL_W-1:0],
                           cmd_tdata_i[VAL_W +: POS_W]);
      end
    end
    err_count_o <= mismatches;
    pending_o   <= owed_results_q.size();
    list_size_o <= shadow_count[CNT_W-1:0];
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for positional_list_store_core
// Drives a directed command sequence over the empty, partly filled and full
// list, then random command streams with bursty input and a stalling result
// receiver; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import pls_pkg::*;

  localparam int RES_W      = ((CNT_W + VAL_W + 7) / 8) * 8;
  localparam int RAND_CMDS  = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 2 * CAPACITY;
  // Codes outside the command set; the block must drop them.
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata = '0;
  logic [OP_W-1:0]  s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RES_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]  m_axis_tuser;
  logic             m_axis_tlast;

  int               err_count;
  int               pending;
  logic [CNT_W-1:0] list_size;
  int unsigned      burst_left = 0;
  int unsigned      idle_cycles = 0;

  positional_list_store_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  pls_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_tvalid_i (s_axis_tvalid),
    .cmd_tready_i (s_axis_tready),
    .cmd_tdata_i  (s_axis_tdata),
    .cmd_tuser_i  (s_axis_tuser),
    .res_tvalid_i (m_axis_tvalid),
    .res_tready_i (m_axis_tready),
    .res_tdata_i  (m_axis_tdata),
    .res_tuser_i  (m_axis_tuser),
    .res_tlast_i  (m_axis_tlast),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .list_size_o  (list_size)
  );

  // 50 MHz clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The receiver switches between always ready, random stalls, sparse
  // acceptance and a solid stall, each for a stretch of random length.
  always @(posedge clk_i) begin
    static int unsigned mode = 0;
    static int unsigned stretch = 0;
    if (stretch == 0) begin
      mode    = $urandom_range(0, 3);
      stretch = (mode == 3) ? $urandom_range(1, 25) : $urandom_range(5, 60);
    end
    stretch--;
    case (mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one command and hold it until the block takes it. Commands come in
  // bursts; between bursts valid usually drops for a random gap with junk on the bus.
  task automatic send_list_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 48'({$urandom, $urandom});
        s_axis_tuser  <= OP_W'($urandom_range(0, 7));
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, val};
    s_axis_tuser  <= op;
    do begin
      @(posedge clk_i);
    end while (!(s_axis_tvalid && s_axis_tready));
    burst_left--;
  endtask

  // Values lean toward the signed extremes.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Positions are mostly in range, with the borders and wild values mixed in.
  function automatic logic [POS_W-1:0] pick_position(int unsigned size);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'($urandom_range(0, 65535));
      2:       return POS_W'(size + 1);
      3:       return POS_W'(size + 2);
      4:       return POS_W'(size);
      default: return POS_W'($urandom_range(1, size + 1));
    endcase
  endfunction

  initial begin
    int unsigned taken;
    int unsigned grow_pct;
    int unsigned r;
    logic [OP_W-1:0] op;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Empty list: every delete and the dump report empty, bad inserts rejected.
    send_list_cmd(OP_DUMP, '0, '0);
    send_list_cmd(OP_DEL_FIRST, '0, '0);
    send_list_cmd(OP_DEL_LAST, '0, '0);
    send_list_cmd(OP_DEL_POS, '0, 16'hFFFF);
    send_list_cmd(OP_INSERT, 32'h1234_5678, 16'd0);
    send_list_cmd(OP_INSERT, 32'h1234_5678, 16'd2);
    // Build a short list: head, tail, middle and end insertion.
    send_list_cmd(OP_INSERT, 32'h8000_0000, 16'd1);
    send_list_cmd(OP_APPEND, 32'h7FFF_FFFF, 16'hFFFF);
    send_list_cmd(OP_INSERT, 32'h0000_0000, 16'd2);
    send_list_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'd4);
    // Bad delete positions, a reserved code, then a dump of four entries.
    send_list_cmd(OP_DEL_POS, '0, 16'd0);
    send_list_cmd(OP_DEL_POS, '0, 16'd5);
    send_list_cmd(OP_RSVD_7, $urandom, POS_W'($urandom_range(0, 65535)));
    send_list_cmd(OP_DUMP, '0, '0);
    send_list_cmd(OP_DEL_POS, '0, 16'd2);
    // Fill to capacity and hit the full cases, including full over bad position.
    repeat (CAPACITY - 3) send_list_cmd(OP_APPEND, $urandom, '0);
    send_list_cmd(OP_APPEND, 32'h5555_AAAA, '0);
    send_list_cmd(OP_INSERT, 32'h5555_AAAA, 16'd1);
    send_list_cmd(OP_INSERT, 32'h5555_AAAA, 16'd0);
    send_list_cmd(OP_DUMP, '0, '0);
    send_list_cmd(OP_DEL_POS, '0, POS_W'(CAPACITY + 1));
    send_list_cmd(OP_DEL_POS, '0, POS_W'(CAPACITY));
    send_list_cmd(OP_DEL_FIRST, '0, '0);
    send_list_cmd(OP_DEL_LAST, '0, '0);
    send_list_cmd(OP_RSVD_6, $urandom, POS_W'($urandom_range(0, 65535)));

    // Random commands; the growth bias changes every few dozen commands so
    // the list swings between empty and full.
    taken    = 0;
    grow_pct = 50;
    while (taken < RAND_CMDS) begin
      if (taken % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       grow_pct = 70;
          1:       grow_pct = 25;
          default: grow_pct = 48;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
      end else if (r < 11) begin
        op = OP_DUMP;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_DEL_FIRST;
          1:       op = OP_DEL_LAST;
          default: op = OP_DEL_POS;
        endcase
      end
      send_list_cmd(op, pick_value(), pick_position(32'(list_size)));
      if (op != OP_RSVD_6 && op != OP_RSVD_7) begin
        taken++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker count the last command, drain what is still owed, then
    // allow a quiet margin.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
